[sv/number_to_speech_code_sequencer_unit_defines.svh]
// assertion helpers
`ifndef NUMBER_TO_SPEECH_CODE_SEQUENCER_UNIT_DEFINES_SVH
`define NUMBER_TO_SPEECH_CODE_SEQUENCER_UNIT_DEFINES_SVH

`define N2S_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define N2S_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/n2s_pkg.sv]
package n2s_pkg;

   localparam int VALUE_W    = 14;
   localparam int BCD_DIGITS = 5;
   localparam int MAX_DIGITS = 4;
   localparam int RUN_MAX    = 5;
   localparam int CODE_W     = 8;
   localparam int CNT_W      = $clog2(RUN_MAX + 1);
   localparam int STEP_W     = $clog2(VALUE_W + 1);
   localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);

   localparam logic [CODE_W-1:0] CODE_DIGIT0  = 8'hA0;
   localparam logic [CODE_W-1:0] CODE_TEN     = 8'hAA;
   localparam logic [CODE_W-1:0] CODE_HUNDRED = 8'hAB;

   typedef logic [3:0] digit_type;
   typedef digit_type [BCD_DIGITS-1:0] bcd_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef code_type [RUN_MAX-1:0] code_list_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cvt_stat_type;

   function automatic code_type digit_code(input digit_type d);
      return CODE_DIGIT0 + {{(CODE_W-4){1'b0}}, d};
   endfunction

endpackage

[sv/n2s_bcd.sv]
`include "number_to_speech_code_sequencer_unit_defines.svh"

module n2s_bcd
   import n2s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] start_value,
   input  logic               start_mode,
   input  logic               take,
   output cvt_stat_type       stat,
   output bcd_type            digits,
   output logic               mode
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [VALUE_W-1:0]      bin_ff, bin_in;
   logic [4*BCD_DIGITS-1:0] bcd_ff, bcd_in;
   logic                    mode_ff, mode_in;
   logic [4*BCD_DIGITS-1:0] adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      mode_in  = mode_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = STEP_W'(VALUE_W);
               bin_in   = start_value;
               bcd_in   = '0;
               mode_in  = start_mode;
            end
         end
         ST_RUN: begin
            bcd_in  = {adj[4*BCD_DIGITS-2:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      mode_ff <= mode_in;
   end

   assign stat.busy = (state_ff == ST_RUN);
   assign stat.done = (state_ff == ST_DONE);
   assign digits    = bcd_type'(bcd_ff);
   assign mode      = mode_ff;

   `N2S_ASSERT_NOW(a_start_idle, start, state_ff == ST_IDLE, "conversion started while busy")
   `N2S_ASSERT_NEXT(a_run_done, state_ff == ST_RUN && step_ff == STEP_W'(1),
                    state_ff == ST_DONE, "conversion did not finish on last step")

endmodule

[sv/n2s_out.sv]
`include "number_to_speech_code_sequencer_unit_defines.svh"

module n2s_out
   import n2s_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  code_list_type    load_codes,
   input  logic [CNT_W-1:0] load_count,
   output logic             empty,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_code,
   output logic             rsp_last
);

   code_list_type    list_ff, list_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             xfer;

   assign xfer = rsp_valid && rsp_ready;

   always_comb begin
      list_in = list_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         list_in = load_codes;
         cnt_in  = load_count;
      end else if (xfer) begin
         for (int i = 0; i < RUN_MAX - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
         list_in[RUN_MAX-1] = CODE_DIGIT0;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      list_ff <= list_in;
   end

   assign empty     = (cnt_ff == '0);
   assign rsp_valid = !empty;
   assign rsp_code  = list_ff[0];
   assign rsp_last  = (cnt_ff == CNT_W'(1));

   `N2S_ASSERT_NOW(a_load_empty, load, cnt_ff == '0, "run loaded over pending codes")
   `N2S_ASSERT_NOW(a_cnt_range, 1'b1, cnt_ff <= CNT_W'(RUN_MAX), "run count out of range")
   `N2S_ASSERT_NEXT(a_last_ends, xfer && rsp_last, !rsp_valid, "code after last transfer")

endmodule

[sv/number_to_speech_code_sequencer_unit.sv]
// Sequence: bit-serial binary to decimal shifting, then the code run is loaded once the
// output list is empty, then one code per cycle on the rsp channel while rsp_ready is
// high (up to 5 codes). The next number converts while the previous run is still being
// sent, so when codes are taken at once the shifter sets the rate.
// Reset: synchronous, active high; clears the converter state and the pending code count.
module number_to_speech_code_sequencer_unit
   import n2s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_code,
   output logic               rsp_last
);

   cvt_stat_type     stat;
   bcd_type          digits;
   logic             mode;
   logic             out_empty;
   logic             load;
   code_list_type    codes;
   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] width;
   logic [DIG_IDX_W-1:0] idx;

   assign req_ready = !stat.busy && !stat.done;
   assign load      = stat.done && out_empty;

   n2s_bcd u_bcd (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid && req_ready),
      .start_value (req_value),
      .start_mode  (req_mode),
      .take        (load),
      .stat        (stat),
      .digits      (digits),
      .mode        (mode)
   );

   // code run builder
   always_comb begin
      codes = '{default: CODE_DIGIT0};
      count = '0;
      width = CNT_W'(1);
      idx   = '0;
      if (mode) begin
         for (int i = 0; i < BCD_DIGITS; i++) begin
            if (digits[i] != '0) begin
               width = CNT_W'(i + 1);
            end
         end
         if (width <= CNT_W'(MAX_DIGITS)) begin
            count = width;
            for (int i = 0; i < RUN_MAX; i++) begin
               if (CNT_W'(i) < width) begin
                  idx = DIG_IDX_W'(width - CNT_W'(1) - CNT_W'(i));
                  codes[i] = digit_code(digits[idx]);
               end
            end
         end
      end else if (digits[4] == '0 && digits[3] == '0) begin
         if (digits[2] == '0 && digits[1] == '0) begin
            codes[count] = digit_code(digits[0]);
            count = count + CNT_W'(1);
         end else if (digits[2] == '0) begin
            if (digits[1] > 4'd1) begin
               codes[count] = digit_code(digits[1]);
               count = count + CNT_W'(1);
            end
            codes[count] = CODE_TEN;
            count = count + CNT_W'(1);
            if (digits[0] != '0) begin
               codes[count] = digit_code(digits[0]);
               count = count + CNT_W'(1);
            end
         end else begin
            codes[0] = digit_code(digits[2]);
            codes[1] = CODE_HUNDRED;
            count = CNT_W'(2);
            if (digits[1] != '0) begin
               codes[2] = digit_code(digits[1]);
               codes[3] = CODE_TEN;
               count = CNT_W'(4);
               if (digits[0] != '0) begin
                  codes[4] = digit_code(digits[0]);
                  count = CNT_W'(5);
               end
            end else if (digits[0] != '0) begin
               codes[2] = CODE_DIGIT0;
               codes[3] = digit_code(digits[0]);
               count = CNT_W'(4);
            end
         end
      end
   end

   n2s_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_codes (codes),
      .load_count (count),
      .empty      (out_empty),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_code   (rsp_code),
      .rsp_last   (rsp_last)
   );

endmodule

[tb/speech_run_checker.sv]
`timescale 1ns / 100ps

module speech_run_checker
   import n2s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_mode,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_code,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 codes_owed
);

   typedef struct {
      code_type code;
      logic     last;
   } spoken_code_type;

   spoken_code_type owed_codes[$];
   int              bad_transfers = 0;

   function automatic code_type digit_word(input int unsigned d);
      return CODE_DIGIT0 + code_type'(d);
   endfunction

   function automatic void predict_speech_run(input logic [VALUE_W-1:0] value,
                                              input logic mode);
      int unsigned units;
      int unsigned tens;
      int unsigned hundreds;
      int unsigned rest;
      int unsigned digits[$];
      code_type    run[$];
      units    = value % 10;
      tens     = (value / 10) % 10;
      hundreds = value / 100;
      if (!mode) begin
         if (value < 10) begin
            run.push_back(digit_word(value));
         end else if (value < 100) begin
            if (tens > 1) run.push_back(digit_word(tens));
            run.push_back(CODE_TEN);
            if (units != 0) run.push_back(digit_word(units));
         end else if (value < 1000) begin
            run.push_back(digit_word(hundreds));
            run.push_back(CODE_HUNDRED);
            if (tens != 0) begin
               run.push_back(digit_word(tens));
               run.push_back(CODE_TEN);
               if (units != 0) run.push_back(digit_word(units));
            end else if (units != 0) begin
               run.push_back(digit_word(0));
               run.push_back(digit_word(units));
            end
         end
      end else begin
         rest = value;
         do begin
            digits.push_front(rest % 10);
            rest = rest / 10;
         end while (rest != 0);
         if (digits.size() <= MAX_DIGITS) begin
            foreach (digits[i]) run.push_back(digit_word(digits[i]));
         end
      end
      foreach (run[i]) owed_codes.push_back('{code: run[i], last: (i == run.size() - 1)});
   endfunction

   always @(posedge clock) begin
      spoken_code_type want;
      if (reset) begin
         owed_codes.delete();
         bad_transfers = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_codes.size() == 0) begin
               bad_transfers++;
               if (bad_transfers <= 10)
                  $display("mismatch: unexpected code %h last %b", rsp_code, rsp_last);
            end else begin
               want = owed_codes.pop_front();
               if (rsp_code !== want.code || rsp_last !== want.last) begin
                  bad_transfers++;
                  if (bad_transfers <= 10)
                     $display("mismatch: code %h last %b, expected code %h last %b",
                              rsp_code, rsp_last, want.code, want.last);
               end
            end
         end
         if (req_valid && req_ready) predict_speech_run(req_value, req_mode);
      end
      mismatch_count <= bad_transfers;
      codes_owed     <= owed_codes.size();
   end

endmodule

[tb/tb_number_to_speech_code_sequencer_unit.sv]
`timescale 1ns / 100ps

module tb_number_to_speech_code_sequencer_unit;
   import n2s_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic               req_mode  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_code;
   logic               rsp_last;
   int                 mismatch_count;
   int                 codes_owed;
   int                 cycle_count = 0;
   bit                 no_idle = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   number_to_speech_code_sequencer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_code  (rsp_code),
      .rsp_last  (rsp_last)
   );

   speech_run_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_mode       (req_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code       (rsp_code),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .codes_owed     (codes_owed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_number_to_speech_code_sequencer_unit failed");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin
      int unsigned stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic announce(input logic [VALUE_W-1:0] value, input logic mode);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_mode  <= mode;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int unsigned pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // spoken numerals across all ranges, including too large
      announce(14'd0, 1'b0);
      announce(14'd9, 1'b0);
      announce(14'd10, 1'b0);
      announce(14'd11, 1'b0);
      announce(14'd19, 1'b0);
      announce(14'd20, 1'b0);
      announce(14'd99, 1'b0);
      announce(14'd100, 1'b0);
      announce(14'd101, 1'b0);
      announce(14'd110, 1'b0);
      announce(14'd111, 1'b0);
      announce(14'd305, 1'b0);
      announce(14'd999, 1'b0);
      announce(14'd1000, 1'b0);
      announce(14'd16383, 1'b0);
      // digit by digit, including too many digits
      announce(14'd0, 1'b1);
      announce(14'd7, 1'b1);
      announce(14'd10, 1'b1);
      announce(14'd1234, 1'b1);
      announce(14'd9999, 1'b1);
      announce(14'd10000, 1'b1);
      announce(14'd8192, 1'b1);
      announce(14'd16383, 1'b1);

      for (int i = 0; i < 270; i++) begin
         no_idle = (i >= 90 && i < 130) || (i >= 200 && i < 215);
         pick = $urandom_range(0, 99);
         if (pick < 20)      announce(VALUE_W'($urandom_range(0, 99)), 1'b0);
         else if (pick < 45) announce(VALUE_W'($urandom_range(100, 999)), 1'b0);
         else if (pick < 52) announce(VALUE_W'($urandom_range(0, 16383)), 1'b0);
         else if (pick < 62) announce(VALUE_W'($urandom_range(0, 99)), 1'b1);
         else if (pick < 85) announce(VALUE_W'($urandom_range(0, 9999)), 1'b1);
         else                announce(VALUE_W'($urandom_range(0, 16383)), 1'b1);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (codes_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && codes_owed == 0) begin
         $display("tb_number_to_speech_code_sequencer_unit passed");
      end else begin
         $display("tb_number_to_speech_code_sequencer_unit failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/n2s_pkg.sv
sv/n2s_bcd.sv
sv/n2s_out.sv
sv/number_to_speech_code_sequencer_unit.sv
tb/speech_run_checker.sv
tb/tb_number_to_speech_code_sequencer_unit.sv
